// ----- rtl/tga_rle_pkg.sv -----
// ----------------------------------------------------------------------------
// TGA run-length decoder package
// Widths, register indexes and packet constants shared by the decoder files.
// ----------------------------------------------------------------------------
`default_nettype none

package tga_rle_pkg;

  localparam int BYTE_W      = 8;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int PIX_BYTES   = 4;

  typedef logic [BYTE_W-1:0]      byte_t;
  typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
  typedef logic [CFG_DATA_W-1:0]  cfg_data_t;

  localparam cfg_index_t REG_HAS_ALPHA   = 2'd0;
  localparam cfg_index_t REG_PIXEL_TOTAL = 2'd1;

  // Header bytes at or above the threshold open a run packet.
  localparam byte_t RUN_THRESHOLD = 8'd128;
  localparam byte_t RUN_OFFSET    = 8'd127;

  // Position of the last byte of a pixel in 24-bit and 32-bit mode.
  localparam logic [1:0] LAST_POS_RGB  = 2'd2;
  localparam logic [1:0] LAST_POS_RGBA = 2'd3;

endpackage

`default_nettype wire

// ----- rtl/tga_rle_byte_if.sv -----
// ----------------------------------------------------------------------------
// TGA run-length byte stream interface
// Valid/ready channel carrying one compressed stream byte per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface tga_rle_byte_if;

  logic                valid;
  logic                ready;
  tga_rle_pkg::byte_t  data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);

endinterface

`default_nettype wire

// ----- rtl/tga_rle_pix_if.sv -----
// ----------------------------------------------------------------------------
// TGA run-length pixel stream interface
// Valid/ready channel carrying one decoded pixel and its repeat count per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface tga_rle_pix_if;

  logic                valid;
  logic                ready;
  tga_rle_pkg::byte_t  chan_first;
  tga_rle_pkg::byte_t  chan_second;
  tga_rle_pkg::byte_t  chan_third;
  tga_rle_pkg::byte_t  chan_alpha;
  tga_rle_pkg::byte_t  repeat_count;
  logic                image_done;

  modport source (
    output valid, output chan_first, output chan_second, output chan_third,
    output chan_alpha, output repeat_count, output image_done, input ready
  );
  modport sink (
    input valid, input chan_first, input chan_second, input chan_third,
    input chan_alpha, input repeat_count, input image_done, output ready
  );

endinterface

`default_nettype wire

// ----- rtl/tga_rle_pixel_decoder_core.sv -----
// ----------------------------------------------------------------------------
// TGA run-length pixel decoder
// Parses raw and run packets of a run-length coded TGA stream and emits one
// beat per completed pixel with reversed components and a clipped repeat count.
//
//   Channel   Direction  Beat contents
//   bytes     in         data_byte
//   pixels    out        chan_first/second/third/alpha, repeat_count, image_done
//   cfg_*     in         write enable, register index, write data
//
// One byte is taken per cycle unless a held last byte stalls the input; each
// byte enters the input register, and a pixel is registered as its last byte leaves.
// Header bytes and inner pixel bytes never wait on the output side; only the
// last byte of a pixel holds while the output register is full and stalled.
// Reset (synchronous) leaves 24-bit mode, a one-pixel image and the decoder
// awaiting a packet header. A write to either register restarts the image.
// ----------------------------------------------------------------------------
`default_nettype none

module tga_rle_pixel_decoder_core #(
  parameter int COUNT_BITS = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  tga_rle_pkg::cfg_index_t  cfg_index,
  input  tga_rle_pkg::cfg_data_t   cfg_data,
  tga_rle_byte_if.sink             bytes,
  tga_rle_pix_if.source            pixels
);

  typedef logic [COUNT_BITS-1:0] count_t;

  logic                has_alpha;
  count_t              pixel_total;
  logic                expect_header;
  logic                run_packet;
  tga_rle_pkg::byte_t  packet_pixels_left;
  logic [1:0]          byte_position;
  count_t              pixels_remaining;
  tga_rle_pkg::byte_t  pix_lane [tga_rle_pkg::PIX_BYTES];

  logic                in_vld;
  tga_rle_pkg::byte_t  in_byte;

  logic                out_vld;
  tga_rle_pkg::byte_t  out_first;
  tga_rle_pkg::byte_t  out_second;
  tga_rle_pkg::byte_t  out_third;
  tga_rle_pkg::byte_t  out_alpha;
  tga_rle_pkg::byte_t  out_repeat;
  logic                out_done;

  count_t              total_eff;
  logic [1:0]          last_pos;
  logic                pix_last;
  logic                out_free;
  logic                advance;
  logic                cfg_hit;
  tga_rle_pkg::byte_t  bytes_now [tga_rle_pkg::PIX_BYTES];
  logic                rem_small;
  tga_rle_pkg::byte_t  repeat_val;
  count_t              rem_next;
  logic                done;
  tga_rle_pkg::byte_t  left_next;
  tga_rle_pkg::byte_t  hdr_left;

  assign total_eff = (pixel_total == '0) ? count_t'(1) : pixel_total;
  assign last_pos  = has_alpha ? tga_rle_pkg::LAST_POS_RGBA : tga_rle_pkg::LAST_POS_RGB;
  assign pix_last  = !expect_header && (byte_position == last_pos);
  assign out_free  = !out_vld || pixels.ready;
  assign advance   = in_vld && (!pix_last || out_free);
  assign cfg_hit   = cfg_we && ((cfg_index == tga_rle_pkg::REG_HAS_ALPHA) ||
                                (cfg_index == tga_rle_pkg::REG_PIXEL_TOTAL));

  assign bytes.ready = !in_vld || advance;

  always_comb begin
    for (int i = 0; i < tga_rle_pkg::PIX_BYTES; i++) begin
      bytes_now[i] = (byte_position == 2'(i)) ? in_byte : pix_lane[i];
    end
  end

  assign hdr_left = (in_byte < tga_rle_pkg::RUN_THRESHOLD) ? in_byte + 8'd1
                                                           : in_byte - tga_rle_pkg::RUN_OFFSET;

  // A run never repeats past the end of the image.
  assign rem_small  = pixels_remaining < count_t'(packet_pixels_left);
  assign repeat_val = !run_packet ? 8'd1 :
                      rem_small   ? pixels_remaining[7:0] : packet_pixels_left;
  assign rem_next   = pixels_remaining - count_t'(repeat_val);
  assign done       = (rem_next == '0);
  assign left_next  = run_packet ? 8'd0 : packet_pixels_left - 8'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      has_alpha          <= 1'b0;
      pixel_total        <= count_t'(1);
      expect_header      <= 1'b1;
      run_packet         <= 1'b0;
      packet_pixels_left <= '0;
      byte_position      <= '0;
      pixels_remaining   <= count_t'(1);
      in_vld             <= 1'b0;
      out_vld            <= 1'b0;
    end else begin
      if (bytes.valid && bytes.ready) begin
        in_vld <= 1'b1;
      end else if (advance) begin
        in_vld <= 1'b0;
      end

      if (advance && pix_last) begin
        out_vld <= 1'b1;
      end else if (pixels.ready) begin
        out_vld <= 1'b0;
      end

      if (cfg_hit) begin
        if (cfg_index == tga_rle_pkg::REG_HAS_ALPHA) begin
          has_alpha <= cfg_data[0];
          pixels_remaining <= total_eff;
        end else begin
          pixel_total <= cfg_data[COUNT_BITS-1:0];
          pixels_remaining <= (cfg_data[COUNT_BITS-1:0] == '0) ? count_t'(1)
                                                                : cfg_data[COUNT_BITS-1:0];
        end
        expect_header      <= 1'b1;
        run_packet         <= 1'b0;
        packet_pixels_left <= '0;
        byte_position      <= '0;
      end else if (advance) begin
        if (expect_header) begin
          run_packet         <= (in_byte >= tga_rle_pkg::RUN_THRESHOLD);
          packet_pixels_left <= hdr_left;
          expect_header      <= 1'b0;
          byte_position      <= '0;
        end else if (!pix_last) begin
          byte_position <= byte_position + 2'd1;
        end else begin
          byte_position <= '0;
          if (done) begin
            expect_header      <= 1'b1;
            run_packet         <= 1'b0;
            packet_pixels_left <= '0;
            pixels_remaining   <= total_eff;
          end else begin
            packet_pixels_left <= left_next;
            pixels_remaining   <= rem_next;
            expect_header      <= (left_next == 8'd0);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (bytes.valid && bytes.ready) begin
      in_byte <= bytes.data_byte;
    end
    if (advance && !expect_header) begin
      pix_lane[byte_position] <= in_byte;
    end
    if (advance && pix_last) begin
      out_first  <= bytes_now[2];
      out_second <= bytes_now[1];
      out_third  <= bytes_now[0];
      out_alpha  <= has_alpha ? bytes_now[3] : 8'd0;
      out_repeat <= repeat_val;
      out_done   <= done;
    end
  end

  assign pixels.valid        = out_vld;
  assign pixels.chan_first   = out_first;
  assign pixels.chan_second  = out_second;
  assign pixels.chan_third   = out_third;
  assign pixels.chan_alpha   = out_alpha;
  assign pixels.repeat_count = out_repeat;
  assign pixels.image_done   = out_done;

  a_left_nonzero: assert property (@(posedge clk) disable iff (rst)
    !expect_header |-> packet_pixels_left != 8'd0)
    else $error("Packet open with no pixels left.");

  a_remaining_nonzero: assert property (@(posedge clk) disable iff (rst)
    pixels_remaining != '0)
    else $error("Image pixel count reached zero without a restart.");

  a_pos_rgb: assert property (@(posedge clk) disable iff (rst)
    !has_alpha |-> byte_position != tga_rle_pkg::LAST_POS_RGBA)
    else $error("Fourth byte position reached in 24-bit mode.");

  a_done_restart: assert property (@(posedge clk) disable iff (rst)
    (advance && pix_last && done && !cfg_hit) |=>
      (expect_header && pixels_remaining == $past(total_eff) && out_vld && out_done))
    else $error("Completed image did not restart the decoder.");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_vld && !pixels.ready) |-> !(advance && pix_last))
    else $error("Pending pixel beat overwritten.");

endmodule

`default_nettype wire
